[rtl/ready_queue_with_job_selection_assert.svh]
// ----------------------------------------------------------------------------
// Ready queue assertion macros
// Shared property wrappers for the ready queue checks.
// ----------------------------------------------------------------------------
`ifndef READY_QUEUE_WITH_JOB_SELECTION_ASSERT_SVH
`define READY_QUEUE_WITH_JOB_SELECTION_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RQJS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RQJS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rqjs_pkg.sv]
// ----------------------------------------------------------------------------
// Ready queue package
// Types, codes and word layout shared by the ready queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rqjs_pkg;

    localparam int OP_W       = 3;
    localparam int ST_W       = 2;
    localparam int POS_W      = 4;
    localparam int OCC_W      = 5;
    localparam int ENTRY_W    = 40;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int IN_PAD_W   = IN_DATA_W - ENTRY_W - POS_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - ENTRY_W - POS_W - OCC_W;

    localparam logic [OP_W-1:0] OP_ENQ    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ    = 3'd1;
    localparam logic [OP_W-1:0] OP_SHORT  = 3'd2;
    localparam logic [OP_W-1:0] OP_HIGH   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

    // pid in the low bits
    typedef struct packed {
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] pid;
    } t_entry;

    typedef enum logic [1:0] {
        MD_SHORT,
        MD_HIGH,
        MD_SHIFT
    } t_mode;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ECHO,
        SRC_BEST
    } t_src;

    typedef struct packed {
        logic            load;
        logic            enq;
        logic            sweep_start;
        logic            from_pos;
        logic            sweep;
        t_mode           mode;
        logic            shrink;
        logic            post;
        logic [ST_W-1:0] st;
        t_src            src;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            pos_bad;
        logic            sweep_done;
        logic            out_busy;
    } t_stat;

endpackage

[rtl/rqjs_ctrl.sv]
// ----------------------------------------------------------------------------
// Ready queue controller
// Sequences decode, memory sweep and result posting for one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rqjs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  rqjs_pkg::t_stat i_stat,
    output rqjs_pkg::t_cmd  o_cmd
);
    import rqjs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    t_mode  w_mode;

    always_comb begin
        unique case (i_stat.op)
            OP_SHORT: w_mode = MD_SHORT;
            OP_HIGH:  w_mode = MD_HIGH;
            default:  w_mode = MD_SHIFT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = w_mode;
        o_cmd.src  = SRC_ZERO;
        o_s_tready = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.op == OP_ENQ) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.post = 1'b1;
                        n_state    = S_IDLE;
                        if (i_stat.full) begin
                            o_cmd.st = ST_FULL;
                        end else begin
                            o_cmd.enq = 1'b1;
                            o_cmd.st  = ST_OK;
                            o_cmd.src = SRC_ECHO;
                        end
                    end
                end else if (i_stat.op > OP_REMOVE) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.post = 1'b1;
                        o_cmd.st   = ST_OK;
                        n_state    = S_IDLE;
                    end
                end else if (i_stat.empty) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.post = 1'b1;
                        o_cmd.st   = ST_EMPTY;
                        n_state    = S_IDLE;
                    end
                end else if (i_stat.op == OP_REMOVE && i_stat.pos_bad) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.post = 1'b1;
                        o_cmd.st   = ST_BADPOS;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.sweep_start = 1'b1;
                    o_cmd.from_pos    = (i_stat.op == OP_REMOVE);
                    n_state           = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.post   = 1'b1;
                    o_cmd.st     = ST_OK;
                    o_cmd.src    = SRC_BEST;
                    o_cmd.shrink = (i_stat.op == OP_DEQ) || (i_stat.op == OP_REMOVE);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/rqjs_dp.sv]
// ----------------------------------------------------------------------------
// Ready queue datapath
// Entry memory, occupancy, sweep pipeline, best-entry tracking, output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rqjs_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rqjs_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic [rqjs_pkg::OP_W-1:0]           i_s_tuser,
    input  rqjs_pkg::t_cmd                      i_cmd,
    output rqjs_pkg::t_stat                     o_stat,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [rqjs_pkg::ST_W-1:0]           o_m_tuser,
    output logic [rqjs_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import rqjs_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [OP_W-1:0]           r_op;
    t_entry                    r_item;
    logic [POS_W-1:0]          r_pos;
    logic [CW-1:0]             r_count, n_count;
    t_entry                    r_mem [QUEUE_DEPTH];
    logic [CW-1:0]             r_iss;
    logic                      r_dv;
    logic                      r_first;
    logic [IW-1:0]             r_didx;
    t_entry                    r_rdata;
    t_entry                    r_best;
    logic [IW-1:0]             r_best_pos;
    logic                      r_out_valid;
    logic [ST_W-1:0]           r_out_st;
    logic [OUT_DATA_W-1:0]     r_out_data;

    logic [CW+POS_W-1:0]       w_pos_ext;
    logic [CW+POS_W-1:0]       w_cnt_ext;
    logic                      w_issue;
    logic                      w_shift_wr;
    logic                      w_wr_en;
    logic [IW-1:0]             w_wr_addr;
    t_entry                    w_wr_data;
    logic                      w_better;
    t_entry                    w_res;
    logic [IW-1:0]             w_res_idx;
    logic [IW+POS_W-1:0]       w_res_idx_ext;
    logic [CW+OCC_W-1:0]       w_occ_ext;

    assign w_pos_ext = {{CW{1'b0}}, r_pos};
    assign w_cnt_ext = {{POS_W{1'b0}}, r_count};

    assign o_stat.op         = r_op;
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.pos_bad    = (w_pos_ext >= w_cnt_ext);
    assign o_stat.sweep_done = (r_iss == r_count) && !r_dv;
    assign o_stat.out_busy   = r_out_valid && !i_m_tready;

    assign w_issue    = i_cmd.sweep && (r_iss < r_count);
    assign w_shift_wr = i_cmd.sweep && r_dv && !r_first && (i_cmd.mode == MD_SHIFT);
    assign w_wr_en    = i_cmd.enq || w_shift_wr;
    assign w_wr_addr  = i_cmd.enq ? r_count[IW-1:0] : (r_didx - 1'b1);
    assign w_wr_data  = i_cmd.enq ? r_item : r_rdata;

    always_comb begin
        unique case (i_cmd.mode)
            MD_SHORT: w_better = (r_rdata.burst < r_best.burst);
            MD_HIGH:  w_better = (r_rdata.prio > r_best.prio);
            default:  w_better = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.enq) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.shrink) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.src)
            SRC_ECHO: begin
                w_res     = r_item;
                w_res_idx = r_count[IW-1:0];
            end
            SRC_BEST: begin
                w_res     = r_best;
                w_res_idx = r_best_pos;
            end
            default: begin
                w_res     = '0;
                w_res_idx = '0;
            end
        endcase
    end

    assign w_res_idx_ext = {{POS_W{1'b0}}, w_res_idx};
    assign w_occ_ext     = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_s_tuser;
            r_item <= t_entry'(i_s_tdata[ENTRY_W-1:0]);
            r_pos  <= i_s_tdata[ENTRY_W+POS_W-1:ENTRY_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[r_iss[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // compare / move acts in the cycle after its read is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv    <= 1'b0;
            r_first <= 1'b0;
        end else if (i_cmd.sweep_start) begin
            r_dv    <= 1'b0;
            r_first <= 1'b1;
        end else if (i_cmd.sweep) begin
            r_dv <= w_issue;
            if (r_dv) begin
                r_first <= 1'b0;
            end
        end else begin
            r_dv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_iss <= i_cmd.from_pos ? w_pos_ext[CW-1:0] : '0;
        end else if (w_issue) begin
            r_iss <= r_iss + 1'b1;
        end
        if (i_cmd.sweep) begin
            r_didx <= r_iss[IW-1:0];
            if (r_dv && (r_first || w_better)) begin
                r_best     <= r_rdata;
                r_best_pos <= r_didx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_st   <= i_cmd.st;
            r_out_data <= {{OUT_PAD_W{1'b0}}, w_occ_ext[OCC_W-1:0],
                           w_res_idx_ext[POS_W-1:0], w_res};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_st;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/ready_queue_with_job_selection.sv]
// ----------------------------------------------------------------------------
// Ready queue with job selection
// Bounded ordered process queue with enqueue, dequeue, shortest-burst and
// highest-priority search, and remove by position.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the opcode; tdata carries pid, priority, burst
// and position. Output stream: tuser carries the status; tdata carries pid,
// priority, burst, position and occupancy. One result word per input word.
// One word is processed at a time; the next is taken once the result has
// been loaded into the output register, even if that word is still stalled.
// Enqueue, unused opcodes and error cases: the result is posted from the
// decode state, and the input is ready again once it is loaded.
// Dequeue, finds and remove sweep the entry memory through its single read
// port, one entry per cycle from the start slot to the tail.
// A stalled output holds its word; a finished result then waits inside until
// the output register frees, and the input stays not ready.
// Reset empties the queue at once; no clearing pass over the entry memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ready_queue_with_job_selection_assert.svh"

module ready_queue_with_job_selection #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [15:0] pid, [23:16] priority_req, [39:24] burst, [43:40] position
    input  logic [rqjs_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] opcode
    input  logic [rqjs_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [15:0] out_pid, [23:16] out_priority, [39:24] out_burst,
    // [43:40] out_position, [48:44] occupancy
    output logic [rqjs_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [rqjs_pkg::ST_W-1:0]       o_m_axis_tuser
);
    import rqjs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    logic                     w_in_acc;
    logic                     w_out_hold;
    logic                     w_out_err;
    logic                     w_out_empty;
    logic [ENTRY_W+POS_W-1:0] w_out_ent;
    logic [OCC_W-1:0]         w_out_occ;

    rqjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rqjs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tdata  (o_m_axis_tdata)
    );

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_hold  = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_err   = o_m_axis_tvalid && (o_m_axis_tuser != ST_OK);
    assign w_out_empty = o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY);
    assign w_out_ent   = o_m_axis_tdata[ENTRY_W+POS_W-1:0];
    assign w_out_occ   = o_m_axis_tdata[ENTRY_W+POS_W +: OCC_W];

    `RQJS_ASSERT_NEXT(a_one_word_at_a_time, w_in_acc, !o_s_axis_tready, "second word taken")
    `RQJS_ASSERT_NOW(a_error_fields_zero, w_out_err, w_out_ent == '0, "error word has an entry")
    `RQJS_ASSERT_NOW(a_empty_occupancy, w_out_empty, w_out_occ == '0, "empty with entries left")
    `RQJS_ASSERT_NOW(a_no_post_while_busy, w_cmd.post, !w_out_hold, "stalled word overwritten")

endmodule

[tb/tb_ready_queue_with_job_selection.sv]
// ----------------------------------------------------------------------------
// Ready queue with job selection testbench
// Streams opcode words into the queue and scores every result word against
// an in-bench queue model: enqueue, dequeue, shortest-burst and
// highest-priority search, remove by position and the error codes.
// Directed corner words first, then phases of random traffic that fill and
// drain the queue, with random sender gaps, receiver stalls and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ready_queue_with_job_selection;
    import rqjs_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_WORDS  = 650;
    localparam int PRINT_CAP   = 40;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 60;

    // opcodes with no operation
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_PERIODIC,
        SINK_SPARSE
    } t_sink;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    typedef struct {
        logic [OP_W-1:0]  op;
        t_entry           ent;
        logic [POS_W-1:0] pos;
    } t_cmd_word;

    typedef struct {
        logic [ST_W-1:0]  st;
        t_entry           ent;
        logic [POS_W-1:0] pos;
        logic [OCC_W-1:0] occ;
    } t_result_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [15:0] pid, [23:16] priority_req, [39:24] burst, [43:40] position
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // [2:0] opcode
    logic [OP_W-1:0]       i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [15:0] out_pid, [23:16] out_priority, [39:24] out_burst,
    // [43:40] out_position, [48:44] occupancy
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // [1:0] status
    logic [ST_W-1:0]       o_m_axis_tuser;

    t_cmd_word    cmd_words [$];
    t_result_word expected_results [$];

    t_entry    model_slots [DEPTH];
    int        model_fill = 0;
    int        plan_fill = 0;
    int        mismatches = 0;
    t_cmd_word word_on_bus;
    int        gap_left = 0;
    int        run_left = 0;
    int        results_seen = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        mode_left = 0;
    int        sink_phase = 0;
    t_sink     sink_mode = SINK_OPEN;

    ready_queue_with_job_selection #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic void close_gap(input int at);
        for (int i = at; i + 1 < model_fill; i++) begin
            model_slots[i] = model_slots[i + 1];
        end
        model_fill--;
    endfunction

    function automatic t_result_word predict_queue_op(input t_cmd_word w);
        t_result_word r;
        int best;
        bit better;
        r.st  = ST_OK;
        r.ent = '0;
        r.pos = '0;
        if (w.op == OP_ENQ) begin
            if (model_fill >= DEPTH) begin
                r.st = ST_FULL;
            end else begin
                model_slots[model_fill] = w.ent;
                r.ent = w.ent;
                r.pos = model_fill[POS_W-1:0];
                model_fill++;
            end
        end else if (w.op > OP_REMOVE) begin
            r.st = ST_OK;
        end else if (model_fill == 0) begin
            r.st = ST_EMPTY;
        end else if (w.op == OP_DEQ) begin
            r.ent = model_slots[0];
            close_gap(0);
        end else if (w.op == OP_SHORT || w.op == OP_HIGH) begin
            best = 0;
            for (int i = 1; i < model_fill; i++) begin
                if (w.op == OP_SHORT) begin
                    better = model_slots[i].burst < model_slots[best].burst;
                end else begin
                    better = model_slots[i].prio > model_slots[best].prio;
                end
                if (better) begin
                    best = i;
                end
            end
            r.ent = model_slots[best];
            r.pos = best[POS_W-1:0];
        end else if (int'(w.pos) >= model_fill) begin
            r.st = ST_BADPOS;
        end else begin
            r.ent = model_slots[w.pos];
            r.pos = w.pos;
            close_gap(int'(w.pos));
        end
        r.occ = model_fill[OCC_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // tracks occupancy while planning so removes mostly hit live slots
    task automatic add_word(input logic [OP_W-1:0] op, input logic [15:0] pid,
                            input logic [7:0] prio, input logic [15:0] burst,
                            input logic [POS_W-1:0] pos);
        t_cmd_word w;
        w.op        = op;
        w.ent.pid   = pid;
        w.ent.prio  = prio;
        w.ent.burst = burst;
        w.pos       = pos;
        cmd_words.push_back(w);
        if (op == OP_ENQ && plan_fill < DEPTH) begin
            plan_fill++;
        end else if (op == OP_DEQ && plan_fill > 0) begin
            plan_fill--;
        end else if (op == OP_REMOVE && int'(pos) < plan_fill) begin
            plan_fill--;
        end
    endtask

    // small values give ties, the rest cover the extremes and all bits
    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = 16'($urandom_range(0, 3));
            2: v = '0;
            3: v = '1;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin : drive_proc
        t_cmd_word nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left = 0;
            run_left = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(predict_queue_op(word_on_bus));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0 || cmd_words.size() == 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end else begin
                    nxt = cmd_words.pop_front();
                    word_on_bus = nxt;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {{IN_PAD_W{1'b0}}, nxt.pos, nxt.ent};
                    i_s_axis_tuser  <= nxt.op;
                    if (run_left <= 1) begin
                        run_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        run_left--;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : sink_proc
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = t_sink'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                sink_phase++;
                case (sink_mode)
                    SINK_OPEN:     i_m_axis_tready <= 1'b1;
                    SINK_COIN:     i_m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_PERIODIC: i_m_axis_tready <= (sink_phase % 4 == 0);
                    default:       i_m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_result_word want;
        t_entry       got_ent;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_ent = o_m_axis_tdata[ENTRY_W-1:0];
            if (expected_results.size() == 0) begin
                note_mismatch("word with nothing expected", o_m_axis_tdata[15:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tuser !== want.st)
                    note_mismatch("status", 16'(o_m_axis_tuser), 16'(want.st));
                if (got_ent.pid !== want.ent.pid)
                    note_mismatch("pid", got_ent.pid, want.ent.pid);
                if (got_ent.prio !== want.ent.prio)
                    note_mismatch("priority", 16'(got_ent.prio), 16'(want.ent.prio));
                if (got_ent.burst !== want.ent.burst)
                    note_mismatch("burst", got_ent.burst, want.ent.burst);
                if (o_m_axis_tdata[ENTRY_W +: POS_W] !== want.pos)
                    note_mismatch("position", 16'(o_m_axis_tdata[ENTRY_W +: POS_W]),
                                  16'(want.pos));
                if (o_m_axis_tdata[ENTRY_W+POS_W +: OCC_W] !== want.occ)
                    note_mismatch("occupancy", 16'(o_m_axis_tdata[ENTRY_W+POS_W +: OCC_W]),
                                  16'(want.occ));
            end
        end
    end

    initial begin : limit_proc
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : main_proc
        t_phase           phase;
        int               phase_len;
        int               enq_pct;
        int               roll;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;

        // empty queue, spare opcodes
        add_word(OP_DEQ, 16'($urandom), 8'($urandom), 16'($urandom), 4'($urandom));
        add_word(OP_SHORT, '0, '0, '0, '0);
        add_word(OP_HIGH, '1, '1, '1, '1);
        add_word(OP_REMOVE, '0, '0, '0, '0);
        for (int k = OP_SPARE_A; k <= OP_SPARE_C; k++) begin
            add_word(OP_W'(k), 16'($urandom), 8'($urandom), 16'($urandom), 4'($urandom));
        end
        // extremes and ties on both keys
        add_word(OP_ENQ, 16'h0000, 8'h00, 16'h0000, 4'hf);
        add_word(OP_ENQ, 16'hffff, 8'hff, 16'hffff, 4'h0);
        add_word(OP_ENQ, 16'h1234, 8'hff, 16'h0000, 4'h5);
        add_word(OP_ENQ, 16'h8001, 8'h80, 16'h8000, 4'ha);
        add_word(OP_SHORT, '0, '0, '0, '0);
        add_word(OP_HIGH, '0, '0, '0, '0);
        add_word(OP_SPARE_A, '1, '1, '1, '1);
        add_word(OP_REMOVE, '0, '0, '0, 4'd15);
        add_word(OP_REMOVE, '0, '0, '0, 4'd4);
        add_word(OP_REMOVE, '0, '0, '0, 4'd1);
        add_word(OP_REMOVE, '0, '0, '0, 4'd2);
        add_word(OP_DEQ, '0, '0, '0, '0);
        add_word(OP_DEQ, '0, '0, '0, '0);
        add_word(OP_DEQ, '0, '0, '0, '0);

        // random phases that fill to overflow, drain to empty, or churn
        while (cmd_words.size() < RAND_WORDS) begin
            phase     = t_phase'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 60);
            enq_pct   = (phase == PH_FILL) ? 75 : (phase == PH_DRAIN) ? 20 : 45;
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                pos  = 4'($urandom);
                if (roll < enq_pct) begin
                    op = OP_ENQ;
                end else if (roll < enq_pct + 3) begin
                    op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
                end else begin
                    op = OP_W'($urandom_range(OP_DEQ, OP_REMOVE));
                    if (op == OP_REMOVE && plan_fill > 0 && $urandom_range(0, 4) != 0) begin
                        pos = POS_W'($urandom_range(0, plan_fill - 1));
                    end
                end
                add_word(op, pick_value(), 8'(pick_value()), pick_value(), pos);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_words.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
